[hdl/xml_comment_stripper_unit_assert.svh]
// Assertion macros shared by the XML comment stripper RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef XML_COMMENT_STRIPPER_UNIT_ASSERT_SVH
`define XML_COMMENT_STRIPPER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define XCS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("xcs assertion failed: forbidden condition seen");

`define XCS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xcs assertion failed: implication violated");

`define XCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xcs assertion failed: next-cycle implication violated");

`else

`define XCS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define XCS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define XCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/xcs_pkg.sv]
// Types and character constants for the XML comment stripper.
// No dependencies.
package xcs_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] wcount_t;
    typedef logic [2:0] rcount_t;

    localparam byte_t CH_LT    = 8'h3C;
    localparam byte_t CH_BANG  = 8'h21;
    localparam byte_t CH_DASH  = 8'h2D;
    localparam byte_t CH_GT    = 8'h3E;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_LF    = 8'h0A;
    localparam byte_t CH_SPACE = 8'h20;

    localparam int MAX_RESULTS = 4;
    localparam int WIN_DEPTH   = 3;

endpackage

[hdl/xml_comment_stripper_unit.sv]
// XML comment stripper: strips <!-- --> comments and control bytes from a byte stream.
// Depends on xcs_pkg and xml_comment_stripper_unit_assert.svh.
//
// Usage:
//   Slave channel s_*: one request per raw byte. s_tdata = data_byte,
//   s_tuser = end_of_stream (1: no byte, flush held window bytes and reset).
//   Master channel m_*: filtered bytes, CR/LF turned into space. m_tlast marks
//   the final byte produced by one input request.
//   A request is captured in the input register and processed into the
//   result buffer once that buffer is free; its bytes are offered on m_*
//   from the result buffer.
//   Throughput: one request per cycle while each request yields at most one
//   byte and m_tready stays high. A request yielding k bytes holds the 4-entry
//   result buffer until all k are taken, as it drains one byte per cycle;
//   the input register keeps taking one further request during that time.
//   Reset: comment mode and the open window are cleared, both buffers empty.
//   Receiver stall: the result buffer holds its byte, the waiting request
//   stays in the input register, and s_tready drops once both are full.
`include "xml_comment_stripper_unit_assert.svh"

module xml_comment_stripper_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  xcs_pkg::byte_t  s_tdata,   // [7:0] data_byte
    input  logic            s_tuser,   // [0] end_of_stream
    output logic            m_tvalid,
    input  logic            m_tready,
    output xcs_pkg::byte_t  m_tdata,   // [7:0] out_byte
    output logic            m_tlast    // last_of_run
);
    import xcs_pkg::*;

    logic    in_valid_reg, in_valid_next;
    byte_t   in_byte_reg;
    logic    in_eos_reg;

    logic    cm_reg, cm_next;
    logic    wo_reg, wo_next;
    wcount_t wc_reg, wc_next;
    byte_t   wb_reg [WIN_DEPTH];
    byte_t   wb_next [WIN_DEPTH];

    byte_t   res_bytes_reg [MAX_RESULTS];
    byte_t   res_bytes_next [MAX_RESULTS];
    rcount_t res_left_reg, res_left_next;
    wcount_t res_idx_reg, res_idx_next;

    logic    res_free;
    logic    process;
    logic    ok;
    byte_t   v;
    rcount_t n;

    assign m_tvalid = (res_left_reg != 3'd0);
    assign m_tdata  = res_bytes_reg[res_idx_reg];
    assign m_tlast  = (res_left_reg == 3'd1);

    assign res_free = (res_left_reg == 3'd0) || ((res_left_reg == 3'd1) && m_tready);
    assign process  = in_valid_reg && res_free;
    assign s_tready = !in_valid_reg || process;

    // control-byte filter
    always_comb
    begin
        ok = (in_byte_reg >= CH_SPACE) || (in_byte_reg == CH_CR) || (in_byte_reg == CH_LF);
        v  = (in_byte_reg >= CH_SPACE) ? in_byte_reg : CH_SPACE;
    end

    always_comb
    begin
        cm_next = cm_reg;
        wo_next = wo_reg;
        wc_next = wc_reg;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            wb_next[i] = wb_reg[i];
        end
        n = 3'd0;
        res_bytes_next[0] = wb_reg[0];
        res_bytes_next[1] = wb_reg[1];
        res_bytes_next[2] = wb_reg[2];
        res_bytes_next[3] = v;

        if (in_eos_reg)
        begin
            if (!cm_reg && wo_reg)
            begin
                n = {1'b0, wc_reg};
            end
            cm_next = 1'b0;
            wo_next = 1'b0;
            wc_next = 2'd0;
        end
        else if (!wo_reg)
        begin
            if ((!cm_reg && in_byte_reg == CH_LT) || (cm_reg && in_byte_reg == CH_DASH))
            begin
                wb_next[0] = in_byte_reg;
                wc_next    = 2'd1;
                wo_next    = 1'b1;
            end
            else if (!cm_reg && ok)
            begin
                n = 3'd1;
                res_bytes_next[0] = v;
            end
        end
        else if (ok)
        begin
            if (!cm_reg && wc_reg == 2'd3)
            begin
                if (wb_reg[0] == CH_LT && wb_reg[1] == CH_BANG &&
                    wb_reg[2] == CH_DASH && v == CH_DASH)
                begin
                    cm_next = 1'b1;
                end
                else
                begin
                    n = 3'd4;
                end
                wo_next = 1'b0;
                wc_next = 2'd0;
            end
            else if (cm_reg && wc_reg >= 2'd2)
            begin
                if (wb_reg[0] == CH_DASH && wb_reg[1] == CH_DASH && v == CH_GT)
                begin
                    cm_next = 1'b0;
                end
                wo_next = 1'b0;
                wc_next = 2'd0;
            end
            else
            begin
                case (wc_reg)
                    2'd0:    wb_next[0] = v;
                    2'd1:    wb_next[1] = v;
                    default: wb_next[2] = v;
                endcase
                wc_next = wc_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (process)
        begin
            in_valid_next = 1'b0;
        end

        res_left_next = res_left_reg;
        res_idx_next  = res_idx_reg;
        if (process)
        begin
            res_left_next = n;
            res_idx_next  = 2'd0;
        end
        else if (m_tvalid && m_tready)
        begin
            res_left_next = res_left_reg - 3'd1;
            res_idx_next  = res_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cm_reg       <= 1'b0;
            wo_reg       <= 1'b0;
            wc_reg       <= 2'd0;
            res_left_reg <= 3'd0;
            res_idx_reg  <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            res_left_reg <= res_left_next;
            res_idx_reg  <= res_idx_next;
            if (process)
            begin
                cm_reg <= cm_next;
                wo_reg <= wo_next;
                wc_reg <= wc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tuser;
        end
        if (process)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                wb_reg[i] <= wb_next[i];
            end
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                res_bytes_reg[i] <= res_bytes_next[i];
            end
        end
    end

    `XCS_ASSERT_NEVER(a_res_overflow, clk, rst_n, res_left_reg > 3'd4)
    `XCS_ASSERT_IMPLY(a_win_count, clk, rst_n, 1'b1, wo_reg == (wc_reg != 2'd0))
    `XCS_ASSERT_IMPLY(a_dash_win, clk, rst_n, cm_reg && wo_reg, wc_reg != 2'd3)
    `XCS_ASSERT_NEXT(a_hold_item, clk, rst_n, in_valid_reg && !res_free,
                     in_valid_reg && $stable(in_byte_reg) && $stable(in_eos_reg))

endmodule
